### hw/rtl/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg
// Types, opcodes and operation codes shared by the decode, execute and result stages.
// ----------------------------------------------------------------------------
package rsd_pkg;

  // Major opcodes, bits 6:0 of the instruction word.
  localparam logic [6:0] OpcLoad   = 7'h03;
  localparam logic [6:0] OpcOpImm  = 7'h13;
  localparam logic [6:0] OpcSystem = 7'h73;
  localparam logic [6:0] OpcAuipc  = 7'h17;
  localparam logic [6:0] OpcLui    = 7'h37;
  localparam logic [6:0] OpcStore  = 7'h23;
  localparam logic [6:0] OpcOp     = 7'h33;
  localparam logic [6:0] OpcBranch = 7'h63;

  // funct3 and funct7 codes of the supported operations.
  localparam logic [2:0] F3AddSub = 3'd0;
  localparam logic [2:0] F3Word   = 3'd2;
  localparam logic [2:0] F3Blt    = 3'd4;
  localparam logic [6:0] F7Add    = 7'd0;
  localparam logic [6:0] F7Sub    = 7'd32;

  // Instruction format reported with each result.
  typedef enum logic [2:0] {
    KIND_R    = 3'd0,
    KIND_I    = 3'd1,
    KIND_S    = 3'd2,
    KIND_SB   = 3'd3,
    KIND_U    = 3'd4,
    KIND_HALT = 3'd5
  } kind_e;

  // Operation selected by the decoder.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_SUB,
    OP_ADDI,
    OP_LW,
    OP_SW,
    OP_BLT,
    OP_AUIPC
  } op_e;

  // Input item.
  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] instr_pc;
    logic [31:0] src1_value;
    logic [31:0] src2_value;
  } in_t;

  // Result item.
  typedef struct packed {
    kind_e              kind;
    logic [4:0]         dest_index;
    logic [4:0]         src1_index;
    logic [4:0]         src2_index;
    logic signed [31:0] immediate;
    logic [31:0]        alu_value;
    logic               reg_write;
    logic               load_request;
    logic               store_request;
    logic               branch_taken;
    logic               halt;
  } out_t;

  // Decode stage register contents.
  typedef struct packed {
    kind_e       kind;
    op_e         op;
    logic [4:0]  dest_index;
    logic [4:0]  src1_index;
    logic [4:0]  src2_index;
    logic [31:0] immediate;
    logic [31:0] pc;
    logic [31:0] src1_value;
    logic [31:0] src2_value;
  } dec_t;

  // Execute stage register contents.
  typedef struct packed {
    kind_e       kind;
    op_e         op;
    logic [4:0]  dest_index;
    logic [4:0]  src1_index;
    logic [4:0]  src2_index;
    logic [31:0] immediate;
    logic [31:0] alu_value;
    logic        less_than;
  } exe_t;

endpackage

### hw/rtl/rv32_subset_decode_execute.sv
// ----------------------------------------------------------------------------
// rv32_subset_decode_execute
// Decode and execute of an RV32 subset: ADD, SUB, ADDI, LW, SW, BLT, AUIPC.
// ----------------------------------------------------------------------------
// The block takes one instruction with its pc and both source register values
// per transfer and returns one result per instruction, in order. It is a
// three-stage pipeline (decode, adder and compare, flag formation with the
// output register), and a new instruction can be taken in every cycle while
// the output is not stalled. Each stage holds its item while the next one
// cannot take it, so back-pressure on the output reaches the input within the
// same cycle without losing or repeating an item.
module rv32_subset_decode_execute import rsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic dec_valid;
  logic dec_ready;
  dec_t dec_data;
  logic exe_valid;
  logic exe_ready;
  exe_t exe_data;

  // Decode stage.
  rsd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (dec_valid),
    .ready_i (dec_ready),
    .data_o  (dec_data)
  );

  // Execute stage.
  rsd_execute u_execute (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .data_i  (dec_data),
    .valid_o (exe_valid),
    .ready_i (exe_ready),
    .data_o  (exe_data)
  );

  // Result stage.
  rsd_result u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (exe_valid),
    .ready_o (exe_ready),
    .data_i  (exe_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

### hw/rtl/rsd_decode.sv
// ----------------------------------------------------------------------------
// rsd_decode
// First pipeline stage: format, register indices, immediate and operation.
// ----------------------------------------------------------------------------
module rsd_decode import rsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  in_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output dec_t data_o
);

  logic       valid_q;
  dec_t       data_q;
  dec_t       data_d;
  logic [6:0] opc;
  logic [4:0] rd;
  logic [2:0] f3;
  logic [4:0] rs1;
  logic [4:0] rs2;
  logic [6:0] f7;
  logic [31:0] w;

  assign w   = data_i.instr_word;
  assign opc = w[6:0];
  assign rd  = w[11:7];
  assign f3  = w[14:12];
  assign rs1 = w[19:15];
  assign rs2 = w[24:20];
  assign f7  = w[31:25];

  // Decode the format, then the operation within it.
  always_comb begin
    data_d            = '0;
    data_d.kind       = KIND_HALT;
    data_d.op         = OP_NONE;
    data_d.pc         = data_i.instr_pc;
    data_d.src1_value = data_i.src1_value;
    data_d.src2_value = data_i.src2_value;
    case (opc)
      OpcLoad, OpcOpImm, OpcSystem: data_d.kind = KIND_I;
      OpcAuipc, OpcLui:             data_d.kind = KIND_U;
      OpcStore:                     data_d.kind = KIND_S;
      OpcOp:                        data_d.kind = KIND_R;
      OpcBranch:                    data_d.kind = KIND_SB;
      default:                      data_d.kind = KIND_HALT;
    endcase
    // An R, I or U format instruction that writes x0 is reported as a halt.
    if ((data_d.kind == KIND_R || data_d.kind == KIND_I || data_d.kind == KIND_U)
        && rd == 5'd0) begin
      data_d.kind = KIND_HALT;
    end
    case (data_d.kind)
      KIND_R: begin
        data_d.dest_index = rd;
        data_d.src1_index = rs1;
        data_d.src2_index = rs2;
        if (f3 == F3AddSub && f7 == F7Add) begin
          data_d.op = OP_ADD;
        end else if (f3 == F3AddSub && f7 == F7Sub) begin
          data_d.op = OP_SUB;
        end
      end
      KIND_I: begin
        data_d.dest_index = rd;
        data_d.src1_index = rs1;
        data_d.immediate  = {{20{w[31]}}, w[31:20]};
        if (f3 == F3AddSub) begin
          data_d.op = OP_ADDI;
        end else if (f3 == F3Word) begin
          data_d.op = OP_LW;
        end
      end
      KIND_S: begin
        data_d.src1_index = rs1;
        data_d.src2_index = rs2;
        data_d.immediate  = {{20{w[31]}}, w[31:25], w[11:7]};
        if (f3 == F3Word) begin
          data_d.op = OP_SW;
        end
      end
      KIND_SB: begin
        data_d.src1_index = rs1;
        data_d.src2_index = rs2;
        data_d.immediate  = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
        if (f3 == F3Blt) begin
          data_d.op = OP_BLT;
        end
      end
      KIND_U: begin
        data_d.dest_index = rd;
        data_d.immediate  = {w[31:12], 12'd0};
        data_d.op         = OP_AUIPC;
      end
      default: begin
        data_d.kind = KIND_HALT;
        data_d.op   = OP_NONE;
      end
    endcase
  end

  // Stage register: it advances when empty or when the next stage takes it.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hw/rtl/rsd_execute.sv
// ----------------------------------------------------------------------------
// rsd_execute
// Second pipeline stage: the shared adder and the signed compare for BLT.
// ----------------------------------------------------------------------------
module rsd_execute import rsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  dec_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output exe_t data_o
);

  logic        valid_q;
  exe_t        data_q;
  exe_t        data_d;
  logic [31:0] opnd_x;
  logic [31:0] opnd_y;
  logic        sub;

  // Operand selection for the single adder.
  always_comb begin
    opnd_x = '0;
    opnd_y = '0;
    sub    = 1'b0;
    case (data_i.op)
      OP_ADD: begin
        opnd_x = data_i.src1_value;
        opnd_y = data_i.src2_value;
      end
      OP_SUB: begin
        opnd_x = data_i.src1_value;
        opnd_y = ~data_i.src2_value;
        sub    = 1'b1;
      end
      OP_ADDI, OP_LW, OP_SW: begin
        opnd_x = data_i.src1_value;
        opnd_y = data_i.immediate;
      end
      OP_BLT, OP_AUIPC: begin
        opnd_x = data_i.pc;
        opnd_y = data_i.immediate;
      end
      default: begin
        opnd_x = '0;
        opnd_y = '0;
      end
    endcase
  end

  always_comb begin
    data_d            = '0;
    data_d.kind       = data_i.kind;
    data_d.op         = data_i.op;
    data_d.dest_index = data_i.dest_index;
    data_d.src1_index = data_i.src1_index;
    data_d.src2_index = data_i.src2_index;
    data_d.immediate  = data_i.immediate;
    data_d.alu_value  = opnd_x + opnd_y + {31'd0, sub};
    data_d.less_than  = $signed(data_i.src1_value) < $signed(data_i.src2_value);
  end

  // Stage register.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### hw/rtl/rsd_result.sv
// ----------------------------------------------------------------------------
// rsd_result
// Third pipeline stage: control flags and the registered result transfer.
// ----------------------------------------------------------------------------
module rsd_result import rsd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  exe_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output out_t data_o
);

  logic valid_q;
  out_t data_q;
  out_t data_d;

  // Flags follow from the decoded operation; halt follows from the format.
  always_comb begin
    data_d               = '0;
    data_d.kind          = data_i.kind;
    data_d.dest_index    = data_i.dest_index;
    data_d.src1_index    = data_i.src1_index;
    data_d.src2_index    = data_i.src2_index;
    data_d.immediate     = data_i.immediate;
    data_d.alu_value     = data_i.alu_value;
    data_d.halt          = (data_i.kind == KIND_HALT);
    case (data_i.op)
      OP_ADD, OP_SUB, OP_ADDI, OP_AUIPC: data_d.reg_write = 1'b1;
      OP_LW: begin
        data_d.reg_write    = 1'b1;
        data_d.load_request = 1'b1;
      end
      OP_SW:   data_d.store_request = 1'b1;
      OP_BLT:  data_d.branch_taken  = data_i.less_than;
      default: data_d.reg_write     = 1'b0;
    endcase
  end

  // Output register.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
